@@ sv/b32e_pkg.sv @@
// b32e_pkg: types, constants and helper functions of the base32 stream encoder
// no dependencies; imported by every module of the block
package b32e_pkg;

  localparam int unsigned SYM_BITS  = 5;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned Q_DEPTH   = 2;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] UPPER_BASE = 8'h41;  // 'A'
  localparam logic [7:0] DIGIT_BASE = 8'h32;  // '2'
  localparam logic [4:0] ALPHA_CNT  = 5'd26;

  localparam logic [2:0] GROUP_LAST = 3'd4;   // byte count wraps after five

  // one decoded byte: what the back part has to put out for it
  typedef struct packed {
    logic [4:0] sym0;
    logic [4:0] sym1;
    logic       two_sym;
    logic       tail_vld;
    logic [4:0] tail_sym;
    logic [2:0] pad_cnt;
    logic       last;
  } b32e_job_t;

  // 5-bit code to ascii symbol
  function automatic logic [7:0] b32_char(input logic [4:0] code);
    logic [7:0] c;
    if (code < ALPHA_CNT) begin
      c = UPPER_BASE + {3'b000, code};
    end else begin
      c = DIGIT_BASE + {3'b000, code - ALPHA_CNT};
    end
    return c;
  endfunction

  // number of '=' characters for a byte count modulo five
  function automatic logic [2:0] pad_len(input logic [2:0] pos);
    logic [2:0] n;
    unique case (pos)
      3'd1:    n = 3'd6;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd3;
      3'd4:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ sv/b32e_if.sv @@
// b32e_if: valid/ready channel interfaces of the base32 stream encoder
// depends on nothing; used by the top level and the testbench
interface b32e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output symbol_char, output run_end, output message_end,
                  input ready);
  modport sink   (input valid, input symbol_char, input run_end, input message_end,
                  output ready);
endinterface

@@ sv/b32e_front.sv @@
// b32e_front: bit gathering front part; splits each byte into symbol codes
// depends on b32e_pkg
module b32e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output b32e_pkg::b32e_job_t job
);
  import b32e_pkg::*;

  logic [3:0]  lbits_r, lbits_nxt;
  logic [2:0]  lcnt_r, lcnt_nxt;
  logic [2:0]  gpos_r, gpos_nxt;

  logic [11:0] bits;
  logic [3:0]  cnt;
  logic [3:0]  sh0, sh1;
  logic [11:0] sh0_w, sh1_w;
  logic        two;
  logic [2:0]  rem;
  logic [11:0] rem_w;
  logic [3:0]  rem_bits;
  logic [8:0]  tail_w;
  logic [2:0]  pos;

  always_comb begin
    bits     = {lbits_r, data_byte};
    cnt      = {1'b0, lcnt_r} + 4'd8;
    two      = (cnt >= 4'd10);
    sh0      = cnt - 4'd5;
    sh1      = two ? (cnt - 4'd10) : 4'd0;
    sh0_w    = bits >> sh0;
    sh1_w    = bits >> sh1;
    rem      = two ? 3'(cnt - 4'd10) : 3'(cnt - 4'd5);
    rem_w    = bits & ~(12'hFFF << rem);
    rem_bits = rem_w[3:0];
    tail_w   = {5'b00000, rem_bits} << (3'd5 - rem);
    pos      = (gpos_r == GROUP_LAST) ? 3'd0 : gpos_r + 3'd1;

    job.sym0     = sh0_w[4:0];
    job.sym1     = sh1_w[4:0];
    job.two_sym  = two;
    job.tail_vld = last_byte && (rem != 3'd0);
    job.tail_sym = tail_w[4:0];
    job.pad_cnt  = last_byte ? pad_len(pos) : 3'd0;
    job.last     = last_byte;

    lbits_nxt = lbits_r;
    lcnt_nxt  = lcnt_r;
    gpos_nxt  = gpos_r;
    if (push) begin
      if (last_byte) begin
        lbits_nxt = 4'd0;
        lcnt_nxt  = 3'd0;
        gpos_nxt  = 3'd0;
      end else begin
        lbits_nxt = rem_bits;
        lcnt_nxt  = rem;
        gpos_nxt  = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbits_r <= 4'd0;
      lcnt_r  <= 3'd0;
      gpos_r  <= 3'd0;
    end else begin
      lbits_r <= lbits_nxt;
      lcnt_r  <= lcnt_nxt;
      gpos_r  <= gpos_nxt;
    end
  end

endmodule

@@ sv/b32e_queue.sv @@
// b32e_queue: two-entry job queue between front and back parts
// depends on b32e_pkg
module b32e_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b32e_pkg::b32e_job_t push_job,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output b32e_pkg::b32e_job_t head
);
  import b32e_pkg::*;

  b32e_job_t  mem_r [Q_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == 2'(Q_DEPTH));
    not_empty  = (cnt_r != 2'd0);
    head       = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sv/b32e_back.sv @@
// b32e_back: character sequencer with output register
// depends on b32e_pkg
module b32e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_vld,
  input  b32e_pkg::b32e_job_t job,
  output logic                pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          symbol_char,
  output logic                run_end,
  output logic                message_end
);
  import b32e_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       ovld_r, ovld_nxt;
  logic [7:0] char_r, char_nxt;
  logic       rend_r, rend_nxt;
  logic       mend_r, mend_nxt;

  logic       adv;
  logic [3:0] total;
  logic [3:0] tail_idx;
  logic       is_end;
  logic [7:0] ch;

  always_comb begin
    total    = 4'd1 + {3'b000, job.two_sym} + {3'b000, job.tail_vld} + {1'b0, job.pad_cnt};
    tail_idx = 4'd1 + {3'b000, job.two_sym};
    is_end   = (idx_r == total - 4'd1);
    priority if (idx_r == 4'd0) begin
      ch = b32_char(job.sym0);
    end else if (idx_r == 4'd1 && job.two_sym) begin
      ch = b32_char(job.sym1);
    end else if (idx_r == tail_idx && job.tail_vld) begin
      ch = b32_char(job.tail_sym);
    end else begin
      ch = PAD_CHAR;
    end

    adv = job_vld && (!ovld_r || out_ready);
    pop = adv && is_end;

    idx_nxt  = idx_r;
    ovld_nxt = ovld_r && !out_ready;
    char_nxt = char_r;
    rend_nxt = rend_r;
    mend_nxt = mend_r;
    if (adv) begin
      idx_nxt  = is_end ? 4'd0 : idx_r + 4'd1;
      ovld_nxt = 1'b1;
      char_nxt = ch;
      rend_nxt = is_end;
      mend_nxt = is_end && job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 4'd0;
      ovld_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
    char_r <= char_nxt;
    rend_r <= rend_nxt;
    mend_r <= mend_nxt;
  end

  assign out_valid   = ovld_r;
  assign symbol_char = char_r;
  assign run_end     = rend_r;
  assign message_end = mend_r;

endmodule

@@ sv/base32_stream_encoder.sv @@
// base32_stream_encoder: top level of the base32 (rfc 4648 alphabet) stream encoder
// depends on b32e_pkg, b32e_if, b32e_front, b32e_queue, b32e_back
//
// usage
//   in_ch  : one message byte per transfer, last_byte set on the final byte
//   out_ch : one ascii character per transfer ('A'-'Z', '2'-'7' or '=')
//            run_end marks the last character caused by an input byte,
//            message_end the last character of the whole message
//   a byte gives one or two symbols; the last byte adds a zero-filled tail
//   symbol for leftover bits and '=' padding up to the 8-character group
// the first character of a byte passes the job queue, then the output register
// throughput: one character per cycle while the receiver is ready; a byte gives
//   one or two characters, a last byte up to 8; set by the single output register
// the front part takes a byte whenever the two-entry job queue has room
// reset (synchronous, rst_n low) clears leftover bits, byte count, queue
//   and the output valid flag; no clearing pass
// when the receiver stalls the output register holds its character, the
//   queue fills and in_ch.ready drops
module base32_stream_encoder (
  input  logic      clk,
  input  logic      rst_n,
  b32e_in_if.sink   in_ch,
  b32e_out_if.source out_ch
);
  import b32e_pkg::*;

  b32e_job_t new_job;
  b32e_job_t head_job;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      in_xfer;

  // byte transfer whenever the queue has room
  assign in_ch.ready = !q_full;
  assign in_xfer     = in_ch.valid && !q_full;

  // front: leftover bits and group position, one byte per transfer
  b32e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .job       (new_job)
  );

  // queue lets the front keep taking bytes while the back sends characters
  b32e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_job  (new_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  // back: walks the characters of the head job into the output register
  b32e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_vld     (q_not_empty),
    .job         (head_job),
    .pop         (q_pop),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .symbol_char (out_ch.symbol_char),
    .run_end     (out_ch.run_end),
    .message_end (out_ch.message_end)
  );

endmodule

@@ sv/b32e_checker.sv @@
// b32e_checker: port-level assertions for the base32 stream encoder
// depends on b32e_pkg; bound to base32_stream_encoder below
module b32e_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] symbol_char,
  input logic       run_end,
  input logic       message_end
);
  import b32e_pkg::*;

  logic out_xfer;
  logic pad_open_r, pad_open_nxt;

  assign out_xfer = out_valid && out_ready;

  // padding has started and not yet reached the end of its run
  always_comb begin
    pad_open_nxt = pad_open_r;
    if (out_xfer) begin
      pad_open_nxt = (symbol_char == PAD_CHAR) && !run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_open_r <= 1'b0;
    end else begin
      pad_open_r <= pad_open_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(symbol_char) && $stable(run_end)
      && $stable(message_end))
    else $error("stalled character changed");

  a_msg_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_end |-> run_end)
    else $error("message end without run end");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (symbol_char >= 8'h41 && symbol_char <= 8'h5A)
      || (symbol_char >= 8'h32 && symbol_char <= 8'h37) || symbol_char == PAD_CHAR)
    else $error("character outside the base32 set");

  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && pad_open_r |-> symbol_char == PAD_CHAR)
    else $error("padding interrupted by a symbol");

  a_pad_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && symbol_char == PAD_CHAR && run_end |-> message_end)
    else $error("padding ends a run that is not the message end");

endmodule

bind base32_stream_encoder b32e_checker u_b32e_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .symbol_char (out_ch.symbol_char),
  .run_end     (out_ch.run_end),
  .message_end (out_ch.message_end)
);

@@ verif/b32e_char_checker.sv @@
`timescale 1ns / 100ps
// b32e_char_checker: watches both channels of the base32 stream encoder and
// predicts the ascii characters of every accepted byte; depends on b32e_pkg
module b32e_char_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_symbol_char,
  input  logic        out_run_end,
  input  logic        out_message_end,
  output int unsigned mismatch_cnt,
  output int unsigned pending_cnt,
  output int unsigned chars_checked
);
  import b32e_pkg::*;

  localparam int unsigned REPORT_MAX = 10;
  localparam logic [255:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  typedef struct packed {
    logic [7:0] symbol_char;
    logic       run_end;
    logic       message_end;
  } char_exp_t;

  char_exp_t   expected_chars [$];
  logic [3:0]  carry_bits = 4'd0;
  logic [2:0]  carry_cnt = 3'd0;
  logic [2:0]  group_pos = 3'd0;
  int unsigned errs = 0;
  int unsigned seen = 0;

  function automatic logic [7:0] code_to_ascii(input int unsigned code);
    return ALPHABET[8 * (31 - code) +: 8];
  endfunction

  // appends the characters one byte causes and advances the encoder state
  function automatic void predict_byte(input logic [7:0] data, input logic is_last);
    int unsigned acc;
    int unsigned nbits;
    int unsigned npad;
    int unsigned n;
    logic [2:0]  pos;
    char_exp_t   row [8];
    nbits = (carry_cnt > 3'd4) ? 4 : int'(carry_cnt);
    acc = ((32'(carry_bits) & ((32'd1 << nbits) - 32'd1)) << 8) | 32'(data);
    nbits = nbits + 8;
    n = 0;
    while (nbits >= 5) begin
      nbits = nbits - 5;
      row[n].symbol_char = code_to_ascii((acc >> nbits) & 32'h1f);
      row[n].run_end = 1'b0;
      row[n].message_end = 1'b0;
      n = n + 1;
    end
    acc = acc & ((32'd1 << nbits) - 32'd1);
    pos = group_pos + 3'd1;
    if (pos >= 3'd5) begin
      pos = 3'd0;
    end
    if (is_last) begin
      if (nbits > 0) begin
        // zero-filled tail symbol for the leftover bits
        row[n].symbol_char = code_to_ascii((acc << (5 - nbits)) & 32'h1f);
        row[n].run_end = 1'b0;
        row[n].message_end = 1'b0;
        n = n + 1;
      end
      case (pos)
        3'd1:    npad = 6;
        3'd2:    npad = 4;
        3'd3:    npad = 3;
        3'd4:    npad = 1;
        default: npad = 0;
      endcase
      repeat (npad) begin
        row[n].symbol_char = PAD_CHAR;
        row[n].run_end = 1'b0;
        row[n].message_end = 1'b0;
        n = n + 1;
      end
      row[n - 1].run_end = 1'b1;
      row[n - 1].message_end = 1'b1;
      carry_bits = 4'd0;
      carry_cnt = 3'd0;
      group_pos = 3'd0;
    end else begin
      row[n - 1].run_end = 1'b1;
      carry_bits = acc[3:0];
      carry_cnt = nbits[2:0];
      group_pos = pos;
    end
    for (int unsigned i = 0; i < n; i++) begin
      expected_chars = {expected_chars, row[i]};
    end
  endfunction

  always @(posedge clk) begin
    char_exp_t want;
    if (!rst_n) begin
      carry_bits = 4'd0;
      carry_cnt = 3'd0;
      group_pos = 3'd0;
      expected_chars.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(in_data_byte, in_last_byte);
      end
      if (out_valid && out_ready) begin
        seen = seen + 1;
        if (expected_chars.size() == 0) begin
          errs = errs + 1;
          if (errs <= REPORT_MAX) begin
            $display("%0t: unexpected character %h run_end %b message_end %b", $realtime,
                     out_symbol_char, out_run_end, out_message_end);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_symbol_char !== want.symbol_char || out_run_end !== want.run_end ||
              out_message_end !== want.message_end) begin
            errs = errs + 1;
            if (errs <= REPORT_MAX) begin
              $display("%0t: mismatch char exp %h got %h, run_end exp %b got %b, %s %b got %b",
                       $realtime, want.symbol_char, out_symbol_char, want.run_end,
                       out_run_end, "message_end exp", want.message_end, out_message_end);
            end
          end
        end
      end
    end
    mismatch_cnt <= errs;
    pending_cnt <= expected_chars.size();
    chars_checked <= seen;
  end

endmodule

@@ verif/tb_base32_stream_encoder.sv @@
`timescale 1ns / 100ps
// tb_base32_stream_encoder: stimulus and verdict for the base32 stream encoder
// depends on b32e_pkg, b32e_if, base32_stream_encoder and b32e_char_checker
module tb_base32_stream_encoder;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 20;     // a last byte needs up to 8 characters
  localparam int unsigned LIMIT_NS     = 3_000_000;
  localparam int unsigned PHASE_BYTES  = 63;     // random bytes per stall pattern

  logic clk = 1'b0;
  logic rst_n;

  b32e_in_if  in_ch ();
  b32e_out_if out_ch ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned chars_checked;

  // idle percentages of the two sides, changed per phase
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  int unsigned bytes_sent;
  int unsigned msgs_sent;

  base32_stream_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b32e_char_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data_byte    (in_ch.data_byte),
    .in_last_byte    (in_ch.last_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_symbol_char (out_ch.symbol_char),
    .out_run_end     (out_ch.run_end),
    .out_message_end (out_ch.message_end),
    .mismatch_cnt    (mismatch_cnt),
    .pending_cnt     (pending_cnt),
    .chars_checked   (chars_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: random stalls on the result channel, held low during reset
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hard stop if the encoder hangs or drops characters
  initial begin
    #(LIMIT_NS);
    $display("[base32_stream_encoder] ERROR");
    $finish;
  end

  // one byte transfer; returns right after the edge that accepted it, with
  // valid still high so back-to-back bytes keep the channel busy
  task automatic send_byte(input logic [7:0] data, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= is_last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    bytes_sent++;
    if (is_last) begin
      msgs_sent++;
    end
  endtask

  // a whole text message, last flag on its final byte
  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_byte(text[i], i == text.len() - 1);
    end
  endtask

  // random messages until at least n_bytes have gone in; mostly short ones
  // so every padding length shows up often, sometimes long ones to wrap groups
  task automatic send_random_messages(input int unsigned n_bytes);
    int unsigned target;
    int unsigned len;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(8, 1);
      end else begin
        len = $urandom_range(24, 9);
      end
      for (int unsigned k = 0; k < len; k++) begin
        send_byte(8'($urandom_range(255)), k == len - 1);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    rx_idle_pct <= 0;
    tx_idle_pct = 0;
    bytes_sent = 0;
    msgs_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: sender mostly busy, receiver mostly stalled
    tx_idle_pct = 27;
    rx_idle_pct <= 88;

    // directed: single-byte extremes, then every group fill from one to
    // five bytes (six, four, three, one and no padding characters)
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_text("f");
    send_text("fo");
    send_text("foo");
    send_text("foob");
    send_text("fooba");
    // six bytes: the byte count wraps past a full group before the last byte
    for (int i = 0; i < 5; i++) begin
      send_byte(8'hff, 1'b0);
    end
    send_byte(8'h00, 1'b1);

    send_random_messages(PHASE_BYTES);

    // phase two: sender mostly idle, receiver mostly ready
    tx_idle_pct = 88;
    rx_idle_pct <= 27;
    send_random_messages(PHASE_BYTES);

    // phase three: full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    send_random_messages(PHASE_BYTES);

    in_ch.valid <= 1'b0;
    @(posedge clk);

    // drain: every predicted character has to come out, then stay quiet
    while (pending_cnt != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d messages over three stall patterns", bytes_sent,
             msgs_sent);
    $display("checked %0d characters, %0d mismatches", chars_checked, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[base32_stream_encoder] OK");
    end else begin
      $display("[base32_stream_encoder] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/b32e_pkg.sv
sv/b32e_if.sv
sv/b32e_front.sv
sv/b32e_queue.sv
sv/b32e_back.sv
sv/base32_stream_encoder.sv
sv/b32e_checker.sv
verif/b32e_char_checker.sv
verif/tb_base32_stream_encoder.sv
